FILE: rtl/tppem_pkg.sv
// ----------------------------------------------------------------------------
// tppem_pkg: shared types and constants
// Item layouts, configuration set, back-end command codes and default sizes
// for the three-phase power and energy meter.
// ----------------------------------------------------------------------------
package tppem_pkg;

    // Field widths fixed by the item layout
    localparam int CURRENT_W  = 16;
    localparam int VOLTAGE_W  = 8;
    localparam int WARMUP_W   = 8;
    localparam int PHASE_P_W  = CURRENT_W + VOLTAGE_W;   // one phase product
    localparam int POWER_W    = 26;
    localparam int ENERGY_W   = 48;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WARMUP   = 2'd2;

    // Register reset values
    localparam int DEF_CURRENT_FRAC_BITS = 8;
    localparam logic [VOLTAGE_W-1:0] VOLTAGE_RST = 8'd230;
    localparam logic [WARMUP_W-1:0]  WARMUP_RST  = 8'd20;

    // Queue depths (powers of two)
    localparam int DEF_CMD_DEPTH = 4;
    localparam int DEF_OUT_DEPTH = 2;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Back-end operations
    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD  = 2'd0;   // warming up: totals held
    localparam op_t OP_ACCUM = 2'd1;   // sum, peak and energy update
    localparam op_t OP_CLEAR = 2'd2;   // zero totals

    typedef struct packed {
        logic                 req_type;
        logic [CURRENT_W-1:0] current_a;
        logic [CURRENT_W-1:0] current_b;
        logic [CURRENT_W-1:0] current_c;
    } in_item_t;

    typedef struct packed {
        logic [POWER_W-1:0]  total_power;
        logic [POWER_W-1:0]  peak_power;
        logic [ENERGY_W-1:0] energy;
        logic                warmed_up;
    } out_item_t;

    typedef struct packed {
        logic [CURRENT_W-1:0] deadband_current;
        logic [VOLTAGE_W-1:0] nominal_voltage;
        logic [WARMUP_W-1:0]  warmup_ticks;
    } cfg_t;

    // Front-to-back command
    typedef struct packed {
        op_t                  op;
        logic                 warmed;
        logic [CURRENT_W-1:0] smooth_a;
        logic [CURRENT_W-1:0] smooth_b;
        logic [CURRENT_W-1:0] smooth_c;
    } cmd_t;

endpackage

FILE: rtl/tppem_fifo.sv
// ----------------------------------------------------------------------------
// tppem_fifo: small synchronous queue
// Register-array queue with a combinational head; write and read may
// happen in the same cycle, also when full.
// ----------------------------------------------------------------------------
module tppem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Overflow and underflow
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full && !rd_en))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

endmodule

FILE: rtl/tppem_front.sv
// ----------------------------------------------------------------------------
// tppem_front: request intake
// Gates and smooths the phase currents, advances the warm-up count and
// turns each item into a hold, accumulate or clear command.
// ----------------------------------------------------------------------------
module tppem_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  tppem_pkg::in_item_t req,
    input  tppem_pkg::cfg_t     cfg,
    output logic               cmd_wr,
    output tppem_pkg::cmd_t     cmd
);
    import tppem_pkg::*;

    logic [CURRENT_W-1:0] smooth_a_reg, smooth_a_next;
    logic [CURRENT_W-1:0] smooth_b_reg, smooth_b_next;
    logic [CURRENT_W-1:0] smooth_c_reg, smooth_c_next;
    logic [WARMUP_W-1:0]  warm_cnt_reg, warm_cnt_next;
    logic [WARMUP_W:0]    warm_inc;

    // Deadband gate, then (old + new) / 2 rounding down
    function automatic logic [CURRENT_W-1:0] gate_smooth(
        input logic [CURRENT_W-1:0] old_val,
        input logic [CURRENT_W-1:0] raw,
        input logic [CURRENT_W-1:0] deadband
    );
        logic [CURRENT_W-1:0] cur;
        logic [CURRENT_W:0]   sum;
        cur = (raw < deadband) ? '0 : raw;
        sum = {1'b0, old_val} + {1'b0, cur};
        return sum[CURRENT_W:1];
    endfunction

    assign warm_inc = {1'b0, warm_cnt_reg} + 1'b1;

    // Classify and update front state
    always_comb
    begin
        smooth_a_next = smooth_a_reg;
        smooth_b_next = smooth_b_reg;
        smooth_c_next = smooth_c_reg;
        warm_cnt_next = warm_cnt_reg;
        cmd.op        = OP_CLEAR;
        cmd.warmed    = (warm_cnt_reg >= cfg.warmup_ticks);
        if (req.req_type == REQ_TICK)
        begin
            smooth_a_next = gate_smooth(smooth_a_reg, req.current_a, cfg.deadband_current);
            smooth_b_next = gate_smooth(smooth_b_reg, req.current_b, cfg.deadband_current);
            smooth_c_next = gate_smooth(smooth_c_reg, req.current_c, cfg.deadband_current);
            if (warm_inc >= {1'b0, cfg.warmup_ticks})
            begin
                warm_cnt_next = cfg.warmup_ticks;
                cmd.op        = OP_ACCUM;
                cmd.warmed    = 1'b1;
            end
            else
            begin
                warm_cnt_next = warm_inc[WARMUP_W-1:0];
                cmd.op        = OP_HOLD;
                cmd.warmed    = 1'b0;
            end
        end
        cmd.smooth_a = smooth_a_next;
        cmd.smooth_b = smooth_b_next;
        cmd.smooth_c = smooth_c_next;
    end

    assign cmd_wr = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_a_reg <= '0;
            smooth_b_reg <= '0;
            smooth_c_reg <= '0;
            warm_cnt_reg <= '0;
        end
        else if (accept)
        begin
            smooth_a_reg <= smooth_a_next;
            smooth_b_reg <= smooth_b_next;
            smooth_c_reg <= smooth_c_next;
            warm_cnt_reg <= warm_cnt_next;
        end
    end

endmodule

FILE: rtl/tppem_back.sv
// ----------------------------------------------------------------------------
// tppem_back: power and energy pipeline
// Three stages: phase products, three-way sum, then total/peak/energy
// update with saturation. The whole pipeline moves together.
// ----------------------------------------------------------------------------
module tppem_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            nominal_voltage,
    input  logic                  cmd_empty,
    input  tppem_pkg::cmd_t       cmd,
    output logic                  cmd_rd,
    input  logic                  res_full,
    input  logic                  res_rd,
    output logic                  res_wr,
    output tppem_pkg::out_item_t  res
);
    import tppem_pkg::*;

    logic advance;

    // Stage 1: phase products
    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic                 s1_warmed_reg;
    logic [PHASE_P_W-1:0] s1_pa_reg, s1_pb_reg, s1_pc_reg;

    // Stage 2: sum
    logic                 s2_valid_reg;
    op_t                  s2_op_reg;
    logic                 s2_warmed_reg;
    logic [POWER_W-1:0]   s2_sum_reg;

    // Accumulated state
    logic [POWER_W-1:0]   total_reg,  total_next;
    logic [POWER_W-1:0]   peak_reg,   peak_next;
    logic [ENERGY_W-1:0]  energy_reg, energy_next;
    logic [ENERGY_W:0]    energy_add;

    assign advance = !res_full || res_rd;
    assign cmd_rd  = advance && !cmd_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= !cmd_empty;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg     <= cmd.op;
            s1_warmed_reg <= cmd.warmed;
            s1_pa_reg     <= PHASE_P_W'(cmd.smooth_a) * PHASE_P_W'(nominal_voltage);
            s1_pb_reg     <= PHASE_P_W'(cmd.smooth_b) * PHASE_P_W'(nominal_voltage);
            s1_pc_reg     <= PHASE_P_W'(cmd.smooth_c) * PHASE_P_W'(nominal_voltage);
            s2_op_reg     <= s1_op_reg;
            s2_warmed_reg <= s1_warmed_reg;
            s2_sum_reg    <= POWER_W'(s1_pa_reg) + POWER_W'(s1_pb_reg)
                           + POWER_W'(s1_pc_reg);
        end
    end

    // Stage 3: total, peak and saturating energy
    assign energy_add = {1'b0, energy_reg} + {{(ENERGY_W - POWER_W + 1){1'b0}}, s2_sum_reg};

    always_comb
    begin
        total_next  = total_reg;
        peak_next   = peak_reg;
        energy_next = energy_reg;
        unique case (s2_op_reg)
            OP_ACCUM:
            begin
                total_next  = s2_sum_reg;
                peak_next   = (peak_reg < s2_sum_reg) ? s2_sum_reg : peak_reg;
                energy_next = energy_add[ENERGY_W] ? '1 : energy_add[ENERGY_W-1:0];
            end
            OP_CLEAR:
            begin
                total_next  = '0;
                peak_next   = '0;
                energy_next = '0;
            end
            default:
            begin
                total_next  = total_reg;
            end
        endcase
    end

    assign res_wr          = advance && s2_valid_reg;
    assign res.total_power = total_next;
    assign res.peak_power  = peak_next;
    assign res.energy      = energy_next;
    assign res.warmed_up   = s2_warmed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            peak_reg   <= '0;
            energy_reg <= '0;
        end
        else if (res_wr)
        begin
            total_reg  <= total_next;
            peak_reg   <= peak_next;
            energy_reg <= energy_next;
        end
    end

    // Peak never below the reported total; energy only grows between clears
    a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> (res.peak_power >= res.total_power))
        else $error("peak below total");
    a_energy_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr && s2_op_reg != OP_CLEAR) |-> (energy_next >= energy_reg))
        else $error("energy decreased without clear");

endmodule

FILE: rtl/three_phase_power_energy_meter.sv
// ----------------------------------------------------------------------------
// three_phase_power_energy_meter: three-phase apparent power and energy
// Per-tick current gating and smoothing, phase power, peak tracking and a
// saturating energy accumulator, with queue-style item ports.
// ----------------------------------------------------------------------------
//  channel   ports                          accepted when
//  request   push, full, req                push && !full
//  result    empty, pop, result             pop && !empty
//  config    cfg_we, cfg_index, cfg_data    cfg_we
//
// One item per clock sustained while results are popped. A taken item goes
// through the command queue, then multiply, sum and accumulate, into results.
// Reset clears all state and loads register defaults; no clearing pass.
// full rises when the four-entry command queue fills; the back pipeline
// freezes while the two-entry result queue is full and not popped.
// ----------------------------------------------------------------------------
module three_phase_power_energy_meter #(
    parameter int CURRENT_FRAC_BITS = tppem_pkg::DEF_CURRENT_FRAC_BITS,
    parameter int CMD_DEPTH         = tppem_pkg::DEF_CMD_DEPTH,
    parameter int OUT_DEPTH         = tppem_pkg::DEF_OUT_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  tppem_pkg::in_item_t                 req,
    output logic                                empty,
    input  logic                                pop,
    output tppem_pkg::out_item_t                result,
    input  logic                                cfg_we,
    input  logic [tppem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tppem_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tppem_pkg::*;

    cfg_t      cfg_reg;
    logic      accept;
    logic      cmd_wr, cmd_rd, cmd_full, cmd_empty;
    cmd_t      cmd_in, cmd_out;
    logic      res_wr, res_full;
    out_item_t res_in;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband_current <= CURRENT_W'(1 << CURRENT_FRAC_BITS);
            cfg_reg.nominal_voltage  <= VOLTAGE_RST;
            cfg_reg.warmup_ticks     <= WARMUP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEADBAND: cfg_reg.deadband_current <= cfg_data;
                REG_VOLTAGE:  cfg_reg.nominal_voltage  <= cfg_data[VOLTAGE_W-1:0];
                REG_WARMUP:   cfg_reg.warmup_ticks     <= cfg_data[WARMUP_W-1:0];
                default:      cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign accept = push && !full;
    assign full   = cmd_full;

    tppem_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cfg    (cfg_reg),
        .cmd_wr (cmd_wr),
        .cmd    (cmd_in)
    );

    tppem_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .rd_en   (cmd_rd),
        .rd_data (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    tppem_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .nominal_voltage (cfg_reg.nominal_voltage),
        .cmd_empty       (cmd_empty),
        .cmd             (cmd_out),
        .cmd_rd          (cmd_rd),
        .res_full        (res_full),
        .res_rd          (pop && !empty),
        .res_wr          (res_wr),
        .res             (res_in)
    );

    tppem_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .rd_en   (pop && !empty),
        .rd_data (result),
        .full    (res_full),
        .empty   (empty)
    );

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for three_phase_power_energy_meter
// A directed table covers the reset values, field extremes, clear requests,
// deadband and warm-up corners. Randomized phases with random register
// settings and random idling on both ports follow. Every popped reading is
// compared field by field against the in-bench meter model or a pinned reading.
// ----------------------------------------------------------------------------
module tb;
    import tppem_pkg::*;

    localparam int          CYCLE_LIMIT  = 250000;
    localparam int          HOLD_CYCLES  = 80;   // long result-side stall
    localparam int          SETTLE       = 6;    // pipeline is three deep
    localparam int          PHASES       = 10;
    localparam int          PHASE_ITEMS  = 55;
    localparam logic [47:0] ENERGY_MAX   = '1;

    // Directed table row: either a register setting or one request item
    typedef struct {
        bit        is_cfg;
        cfg_t      cfg;
        in_item_t  item;
        bit        pinned;   // want holds a hand-written reading
        out_item_t want;
    } row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    logic                   full;
    in_item_t               req       = '0;
    logic                   empty;
    logic                   pop       = 1'b0;
    out_item_t              result;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_DEADBAND;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Meter model state, mirrors the block after reset
    cfg_t                cur_cfg    = {16'(1 << DEF_CURRENT_FRAC_BITS), VOLTAGE_RST, WARMUP_RST};
    logic [15:0]         avg_a      = '0;
    logic [15:0]         avg_b      = '0;
    logic [15:0]         avg_c      = '0;
    logic [7:0]          warm_cnt   = '0;
    logic [POWER_W-1:0]  run_total  = '0;
    logic [POWER_W-1:0]  run_peak   = '0;
    logic [ENERGY_W-1:0] run_energy = '0;

    out_item_t reading_q[$];
    row_t      plan[$];
    int        mismatches = 0;
    int        cycles     = 0;
    bit        idle_on    = 1'b1;
    bit        hold_req   = 1'b0;

    three_phase_power_energy_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Deadband gate, then (old + new) / 2 rounding down
    function automatic logic [15:0] smooth(logic [15:0] old, logic [15:0] raw);
        logic [16:0] s;
        s = {1'b0, old} + ((raw < cur_cfg.deadband_current) ? 17'd0 : {1'b0, raw});
        return s[16:1];
    endfunction

    // Advance the meter model by one request and return the reading it gives
    function automatic out_item_t meter_predict(in_item_t it);
        out_item_t          r;
        logic [8:0]         nxt;
        logic [POWER_W-1:0] sum;
        if (it.req_type == REQ_CLEAR) begin
            run_total  = '0;
            run_peak   = '0;
            run_energy = '0;
        end
        else begin
            avg_a = smooth(avg_a, it.current_a);
            avg_b = smooth(avg_b, it.current_b);
            avg_c = smooth(avg_c, it.current_c);
            nxt   = {1'b0, warm_cnt} + 9'd1;
            if (nxt >= {1'b0, cur_cfg.warmup_ticks}) begin
                warm_cnt  = cur_cfg.warmup_ticks;
                sum       = POWER_W'(avg_a) * POWER_W'(cur_cfg.nominal_voltage)
                          + POWER_W'(avg_b) * POWER_W'(cur_cfg.nominal_voltage)
                          + POWER_W'(avg_c) * POWER_W'(cur_cfg.nominal_voltage);
                run_total = sum;
                if (run_peak < run_total)
                    run_peak = run_total;
                if (run_energy > ENERGY_MAX - run_total)
                    run_energy = ENERGY_MAX;
                else
                    run_energy = run_energy + run_total;
            end
            else begin
                warm_cnt = nxt[7:0];
            end
        end
        r.total_power = run_total;
        r.peak_power  = run_peak;
        r.energy      = run_energy;
        r.warmed_up   = (warm_cnt >= cur_cfg.warmup_ticks);
        return r;
    endfunction

    // Table row builders
    function automatic row_t cfg_row(logic [15:0] db, logic [7:0] v, logic [7:0] w);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.cfg    = {db, v, w};
        return r;
    endfunction

    function automatic row_t req_row(logic kind, logic [15:0] a, logic [15:0] b,
                                     logic [15:0] c);
        row_t r;
        r = '{default: '0};
        r.item.req_type  = kind;
        r.item.current_a = a;
        r.item.current_b = b;
        r.item.current_c = c;
        return r;
    endfunction

    // Reading with all totals zero
    function automatic row_t zero_pin(row_t r, logic warm);
        r.pinned          = 1'b1;
        r.want            = '0;
        r.want.warmed_up  = warm;
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_current();
        int d;
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom_range(0, 65535));
            3, 4, 5: begin
                // straddle the deadband edge
                d = int'(cur_cfg.deadband_current) + int'($urandom_range(0, 4)) - 2;
                if (d < 0)
                    d = 0;
                if (d > 65535)
                    d = 65535;
                return 16'(d);
            end
            6, 7:    return 16'($urandom_range(0, 1023));
            8:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(16'hF000, 16'hFFFF));
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.req_type  = ($urandom_range(0, 99) < 6) ? REQ_CLEAR : REQ_TICK;
        it.current_a = rand_current();
        it.current_b = rand_current();
        it.current_c = rand_current();
        return it;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        case ($urandom_range(0, 5))
            0:       c.deadband_current = '0;
            1:       c.deadband_current = '1;
            2:       c.deadband_current = 16'h0100;
            3:       c.deadband_current = 16'($urandom_range(0, 4095));
            default: c.deadband_current = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       c.nominal_voltage = 8'd1;
            1:       c.nominal_voltage = 8'd255;
            default: c.nominal_voltage = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 9))
            0:       c.warmup_ticks = 8'd255;
            1:       c.warmup_ticks = 8'd1;
            2, 3:    c.warmup_ticks = 8'($urandom_range(1, 30));
            default: c.warmup_ticks = 8'($urandom_range(1, 6));
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // Offer one item until taken, then record its expected reading
    task automatic offer(in_item_t it, bit pinned, out_item_t want);
        out_item_t guess;
        push <= 1'b1;
        req  <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        guess = meter_predict(it);
        reading_q.push_back(pinned ? want : guess);
    endtask

    task automatic rest();
        int n;
        n = gap_len();
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every reading is back and the pipe is empty
    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (reading_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all three registers while the block is idle
    task automatic apply_cfg(cfg_t c);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEADBAND;
        cfg_data  <= c.deadband_current;
        @(posedge clk);
        cfg_index <= REG_VOLTAGE;
        cfg_data  <= CFG_DATA_W'(c.nominal_voltage);
        @(posedge clk);
        cfg_index <= REG_WARMUP;
        cfg_data  <= CFG_DATA_W'(c.warmup_ticks);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_cfg    = c;
    endtask

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random pops, plus one long hold on request
    initial begin : result_taker
        int n;
        wait (rst_n === 1'b1);
        forever begin
            n = gap_len();
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (n > 0) begin
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each popped reading with the oldest expected one
    always @(posedge clk) begin : reading_check
        out_item_t want;
        if (rst_n && pop && !empty) begin
            if (reading_q.size() == 0) begin
                report_mismatch("reading with none expected, total_power",
                                48'(result.total_power), '0);
            end
            else begin
                want = reading_q.pop_front();
                if (result.total_power !== want.total_power)
                    report_mismatch("total_power", 48'(result.total_power),
                                    48'(want.total_power));
                if (result.peak_power !== want.peak_power)
                    report_mismatch("peak_power", 48'(result.peak_power),
                                    48'(want.peak_power));
                if (result.energy !== want.energy)
                    report_mismatch("energy", result.energy, want.energy);
                if (result.warmed_up !== want.warmed_up)
                    report_mismatch("warmed_up", 48'(result.warmed_up),
                                    48'(want.warmed_up));
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        row_t     r;
        in_item_t it;
        int       p;
        int       i;

        // Reset values: still warming, so every total reads zero
        plan.push_back(zero_pin(req_row(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0));
        plan.push_back(zero_pin(req_row(REQ_TICK, 16'h00FF, 16'h0100, 16'h0000), 1'b0));
        plan.push_back(zero_pin(req_row(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0));
        plan.push_back(req_row(REQ_TICK, 16'h0000, 16'h0000, 16'h0000));
        // No deadband, top voltage, accumulate from the first tick
        plan.push_back(cfg_row(16'h0000, 8'd255, 8'd0));
        plan.push_back(req_row(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(req_row(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(req_row(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(req_row(REQ_TICK, 16'h0001, 16'h0001, 16'h0001));
        plan.push_back(req_row(REQ_TICK, 16'h0000, 16'h0000, 16'h0000));
        plan.push_back(zero_pin(req_row(REQ_CLEAR, 16'hFFFF, 16'h0000, 16'hFFFF), 1'b1));
        plan.push_back(req_row(REQ_TICK, 16'h8000, 16'h7FFF, 16'h0001));
        // Widest deadband and zero voltage: phase power is zero
        plan.push_back(cfg_row(16'hFFFF, 8'd0, 8'd1));
        plan.push_back(req_row(REQ_TICK, 16'hFFFF, 16'hFFFE, 16'h0000));
        plan.push_back(req_row(REQ_TICK, 16'hFFFF, 16'hFFFE, 16'h0000));
        // Longest warm-up: totals held while counting
        plan.push_back(cfg_row(16'h0100, 8'd1, 8'd255));
        plan.push_back(req_row(REQ_TICK, 16'h0100, 16'h00FF, 16'hFFFF));
        plan.push_back(req_row(REQ_TICK, 16'h0100, 16'h00FF, 16'hFFFF));
        plan.push_back(req_row(REQ_TICK, 16'h0100, 16'h00FF, 16'hFFFF));
        // Warm-up lowered below the count: clamp and accumulate at once
        plan.push_back(cfg_row(16'h0100, 8'd230, 8'd2));
        plan.push_back(req_row(REQ_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        plan.push_back(req_row(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        plan.push_back(req_row(REQ_TICK, 16'h00FF, 16'h0100, 16'hFFFF));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (plan[k]) begin
            r = plan[k];
            if (r.is_cfg) begin
                apply_cfg(r.cfg);
            end
            else begin
                offer(r.item, r.pinned, r.want);
                rest();
            end
        end

        // Random phases; odd ones idle, phase 2 fills the block against a long hold
        for (p = 0; p < PHASES; p++) begin
            apply_cfg(rand_cfg());
            idle_on = p[0];
            if (p == 2)
                hold_req = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                it = rand_item();
                offer(it, 1'b0, '0);
                rest();
            end
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: three_phase_power_energy_meter.f
rtl/tppem_pkg.sv
rtl/tppem_fifo.sv
rtl/tppem_front.sv
rtl/tppem_back.sv
rtl/three_phase_power_energy_meter.sv
verif/tb.sv
